FILE: hdl/cbmf_pkg.sv
package cbmf_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_RADIUS = 15;

    localparam int CFG_WIDTH_BITS  = 11;
    localparam int CFG_HEIGHT_BITS = 16;
    localparam int CFG_RADIUS_BITS = 4;

    localparam int PIXEL_BITS  = 8;
    localparam int MEAN_BITS   = 16;
    localparam int OUT_COL_BITS = 10;
    localparam int ROW_BITS    = 16;
    localparam int M_DATA_BITS = 48;

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH   = 2'd0,
        REG_IMAGE_HEIGHT  = 2'd1,
        REG_WINDOW_RADIUS = 2'd2,
        REG_UNUSED        = 2'd3
    } cfg_index_t;

endpackage

FILE: hdl/clipped_box_mean_filter_core.sv
// Clipped box mean filter core.
// s_ channel: one pixel per transaction in raster order (tuser = 1 marks a
// flush tick). cfg channel: width, height and radius, picked up when the
// first pixel of an image arrives. m_ channel: window mean (8.8, truncated)
// with its column and row; tlast flags the last result of the image.
// Results trail the input by radius rows plus radius pixels; after the last
// pixel, one flush tick per outstanding result drains them.
// Work per item: an item that produces no result leaves the core idle. An item
// that produces a result runs a window pass and then a division: the window pass
// goes through the single read port of the pixel ring memory, which is read once
// per window pixel, and the bit-serial divider yields one bit per cycle.
// The output register decouples the sides: a new input is taken while a
// result waits; if the receiver stalls, the next result holds in its final
// state until the output register frees up.
// Reset: image position counters clear, registers return to width 1024, height 1024,
// radius 1. The pixel memory is not cleared; only pixels of the current
// image are ever read.
module clipped_box_mean_filter_core #(
    parameter int MAX_WIDTH  = cbmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = cbmf_pkg::DEF_MAX_RADIUS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [cbmf_pkg::PIXEL_BITS-1:0]       s_tdata,  // [7:0] pixel
    input  logic                                  s_tuser,  // [0] mode
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [15:0] mean_value, [25:16] out_column, [41:26] out_row, [47:42] zero
    output logic [cbmf_pkg::M_DATA_BITS-1:0]      m_tdata,
    output logic                                  m_tlast,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [1:0]                            cfg_index,
    input  logic [cbmf_pkg::CFG_HEIGHT_BITS-1:0]  cfg_data
);

    import cbmf_pkg::*;

    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int RW  = $clog2(MAX_RADIUS + 1);
    localparam int LW  = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
    localparam int PW  = LW + 1;
    localparam int AW  = $clog2(2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1);
    localparam int SIDE = 2 * MAX_RADIUS + 1;
    localparam int CW  = $clog2(SIDE * SIDE + 1);
    localparam int SW  = $clog2(SIDE * SIDE * 255 + 1);
    localparam int NW  = SW + 8;
    localparam int YW  = ROW_BITS + 1;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_SETUP = 8'b0000_0010,
        ST_START = 8'b0000_0100,
        ST_SUM   = 8'b0000_1000,
        ST_DRAIN = 8'b0001_0000,
        ST_DIVGO = 8'b0010_0000,
        ST_DIV   = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_WIDTH_BITS-1:0]  cfg_width_reg, cfg_width_next;
    logic [CFG_HEIGHT_BITS-1:0] cfg_height_reg, cfg_height_next;
    logic [CFG_RADIUS_BITS-1:0] cfg_radius_reg, cfg_radius_next;

    logic [WW-1:0]       w_reg, w_next, w_clamp, w_cur;
    logic [ROW_BITS-1:0] h_reg, h_next, h_clamp, h_cur;
    logic [RW-1:0]       r_reg, r_next, r_clamp;
    logic [LW-1:0]       lag_reg, lag_next, lag_clamp, lag_cur;

    logic [WW-1:0]       in_col_reg, in_col_next;
    logic [ROW_BITS-1:0] in_row_reg, in_row_next;
    logic [WW-1:0]       ocol_reg, ocol_next;
    logic [ROW_BITS-1:0] orow_reg, orow_next;
    logic [PW-1:0]       pend_reg, pend_next;
    logic [AW-1:0]       wr_addr_reg, wr_addr_next;

    logic [ROW_BITS-1:0] y0_reg, y0_next, y1_reg, y1_next, yy_reg, yy_next;
    logic [WW-1:0]       x0_reg, x0_next, x1_reg, x1_next, xx_reg, xx_next;
    logic [AW-1:0]       rd_addr_reg, rd_addr_next, row_addr_reg, row_addr_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [SW-1:0]       acc_reg, acc_next;
    logic                rd_pend_reg, rd_pend_next;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_BITS-1:0] m_tdata_reg, m_tdata_next;
    logic                m_tlast_reg, m_tlast_next;

    logic                s_fire, idle_img, all_in, is_flush, out_free, is_last;
    logic                mem_we;
    logic [PIXEL_BITS-1:0] mem_rdata;
    logic [ROW_BITS+WW-1:0] start_prod;
    logic [YW-1:0]       y_hi;
    logic [WW:0]         x_hi;
    logic [NW-1:0]       quo;
    logic                div_start;
    logic                div_done;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign is_flush  = s_tuser;
    assign idle_img  = (in_col_reg == '0) && (in_row_reg == '0) &&
                       (ocol_reg == '0) && (orow_reg == '0);

    // clamp configuration
    always_comb begin
        if (cfg_width_reg == '0) begin
            w_clamp = WW'(1);
        end else if (32'(cfg_width_reg) > MAX_WIDTH) begin
            w_clamp = WW'(MAX_WIDTH);
        end else begin
            w_clamp = WW'(cfg_width_reg);
        end
        h_clamp = (cfg_height_reg == '0) ? ROW_BITS'(1) : cfg_height_reg;
        if (32'(cfg_radius_reg) > MAX_RADIUS) begin
            r_clamp = RW'(MAX_RADIUS);
        end else begin
            r_clamp = RW'(cfg_radius_reg);
        end
        lag_clamp = LW'(r_clamp) * LW'(w_clamp) + LW'(r_clamp);
    end

    assign w_cur   = idle_img ? w_clamp : w_reg;
    assign h_cur   = idle_img ? h_clamp : h_reg;
    assign lag_cur = idle_img ? lag_clamp : lag_reg;
    assign all_in  = (in_row_reg >= h_cur);
    assign out_free = !m_tvalid_reg || m_tready;
    assign is_last  = (ocol_reg == w_reg - 1'b1) && (orow_reg == h_reg - 1'b1);

    assign mem_we     = s_fire && !is_flush && !all_in;
    assign start_prod = y0_reg * w_reg;
    assign y_hi       = YW'(orow_reg) + YW'(r_reg);
    assign x_hi       = (WW+1)'(ocol_reg) + (WW+1)'(r_reg);

    always_comb begin
        cfg_width_next  = cfg_width_reg;
        cfg_height_next = cfg_height_reg;
        cfg_radius_next = cfg_radius_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                REG_IMAGE_WIDTH:   cfg_width_next  = cfg_data[CFG_WIDTH_BITS-1:0];
                REG_IMAGE_HEIGHT:  cfg_height_next = cfg_data;
                REG_WINDOW_RADIUS: cfg_radius_next = cfg_data[CFG_RADIUS_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next    = state_reg;
        w_next        = w_reg;
        h_next        = h_reg;
        r_next        = r_reg;
        lag_next      = lag_reg;
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        ocol_next     = ocol_reg;
        orow_next     = orow_reg;
        pend_next     = pend_reg;
        wr_addr_next  = wr_addr_reg;
        y0_next       = y0_reg;
        y1_next       = y1_reg;
        x0_next       = x0_reg;
        x1_next       = x1_reg;
        yy_next       = yy_reg;
        xx_next       = xx_reg;
        rd_addr_next  = rd_addr_reg;
        row_addr_next = row_addr_reg;
        cnt_next      = cnt_reg;
        acc_next      = acc_reg;
        rd_pend_next  = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        div_start     = 1'b0;

        if (rd_pend_reg) begin
            acc_next = acc_reg + SW'(mem_rdata);
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (idle_img && !is_flush) begin
                        w_next   = w_clamp;
                        h_next   = h_clamp;
                        r_next   = r_clamp;
                        lag_next = lag_clamp;
                    end
                    if (is_flush) begin
                        if (!idle_img && all_in) begin
                            state_next = ST_SETUP;
                        end
                    end else if (!all_in) begin
                        wr_addr_next = wr_addr_reg + 1'b1;
                        pend_next    = pend_reg + 1'b1;
                        if (in_col_reg + 1'b1 >= w_cur) begin
                            in_col_next = '0;
                            in_row_next = in_row_reg + 1'b1;
                        end else begin
                            in_col_next = in_col_reg + 1'b1;
                        end
                        if (pend_reg + 1'b1 > PW'(lag_cur)) begin
                            state_next = ST_SETUP;
                        end
                    end
                end
            end
            ST_SETUP: begin
                y0_next = (orow_reg > ROW_BITS'(r_reg)) ? orow_reg - ROW_BITS'(r_reg) : '0;
                y1_next = (y_hi < YW'(h_reg - 1'b1)) ? y_hi[ROW_BITS-1:0]
                                                      : h_reg - 1'b1;
                x0_next = (ocol_reg > WW'(r_reg)) ? ocol_reg - WW'(r_reg) : '0;
                x1_next = (x_hi < (WW+1)'(w_reg - 1'b1)) ? x_hi[WW-1:0]
                                                          : w_reg - 1'b1;
                state_next = ST_START;
            end
            ST_START: begin
                row_addr_next = AW'(start_prod) + AW'(x0_reg);
                rd_addr_next  = AW'(start_prod) + AW'(x0_reg);
                yy_next       = y0_reg;
                xx_next       = x0_reg;
                cnt_next      = '0;
                acc_next      = '0;
                state_next    = ST_SUM;
            end
            ST_SUM: begin
                rd_pend_next = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (xx_reg == x1_reg) begin
                    if (yy_reg == y1_reg) begin
                        state_next = ST_DRAIN;
                    end else begin
                        yy_next       = yy_reg + 1'b1;
                        xx_next       = x0_reg;
                        row_addr_next = row_addr_reg + AW'(w_reg);
                        rd_addr_next  = row_addr_reg + AW'(w_reg);
                    end
                end else begin
                    xx_next      = xx_reg + 1'b1;
                    rd_addr_next = rd_addr_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DIVGO;
            end
            ST_DIVGO: begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {(M_DATA_BITS-MEAN_BITS-OUT_COL_BITS-ROW_BITS)'(0),
                                     orow_reg, OUT_COL_BITS'(ocol_reg),
                                     quo[MEAN_BITS-1:0]};
                    m_tlast_next  = is_last;
                    pend_next     = pend_reg - 1'b1;
                    if (is_last) begin
                        in_col_next  = '0;
                        in_row_next  = '0;
                        ocol_next    = '0;
                        orow_next    = '0;
                        pend_next    = '0;
                        wr_addr_next = '0;
                    end else if (ocol_reg == w_reg - 1'b1) begin
                        ocol_next = '0;
                        orow_next = orow_reg + 1'b1;
                    end else begin
                        ocol_next = ocol_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cfg_width_reg  <= CFG_WIDTH_BITS'(1024);
            cfg_height_reg <= CFG_HEIGHT_BITS'(1024);
            cfg_radius_reg <= CFG_RADIUS_BITS'(1);
            w_reg          <= '0;
            h_reg          <= '0;
            r_reg          <= '0;
            lag_reg        <= '0;
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            ocol_reg       <= '0;
            orow_reg       <= '0;
            pend_reg       <= '0;
            wr_addr_reg    <= '0;
            rd_pend_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cfg_width_reg  <= cfg_width_next;
            cfg_height_reg <= cfg_height_next;
            cfg_radius_reg <= cfg_radius_next;
            w_reg          <= w_next;
            h_reg          <= h_next;
            r_reg          <= r_next;
            lag_reg        <= lag_next;
            in_col_reg     <= in_col_next;
            in_row_reg     <= in_row_next;
            ocol_reg       <= ocol_next;
            orow_reg       <= orow_next;
            pend_reg       <= pend_next;
            wr_addr_reg    <= wr_addr_next;
            rd_pend_reg    <= rd_pend_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        y0_reg       <= y0_next;
        y1_reg       <= y1_next;
        x0_reg       <= x0_next;
        x1_reg       <= x1_next;
        yy_reg       <= yy_next;
        xx_reg       <= xx_next;
        rd_addr_reg  <= rd_addr_next;
        row_addr_reg <= row_addr_next;
        cnt_reg      <= cnt_next;
        acc_reg      <= acc_next;
        m_tdata_reg  <= m_tdata_next;
        m_tlast_reg  <= m_tlast_next;
    end

    cbmf_store #(
        .AW(AW),
        .DW(PIXEL_BITS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (wr_addr_reg),
        .wr_data (s_tdata),
        .rd_addr (rd_addr_reg),
        .rd_data (mem_rdata)
    );

    cbmf_div #(
        .NW(NW),
        .DW(CW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({acc_reg, 8'b0}),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (quo)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

FILE: hdl/cbmf_store.sv
module cbmf_store #(
    parameter int AW = 15,
    parameter int DW = 8
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [0:(1<<AW)-1];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/cbmf_div.sv
module cbmf_div #(
    parameter int NW = 26,
    parameter int DW = 10
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient
);

    localparam int SCW = $clog2(NW + 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [SCW-1:0]  step_reg, step_next;
    logic [NW-1:0]   dvd_reg, dvd_next;
    logic [DW-1:0]   rem_reg, rem_next;
    logic [DW:0]     rem_sh;
    logic [DW:0]     rem_sub;

    assign rem_sh  = {rem_reg, dvd_reg[NW-1]};
    assign rem_sub = rem_sh - {1'b0, divisor};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = SCW'(NW);
            dvd_next  = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            // restoring step, quotient bits shift in at the bottom
            if (rem_sh >= {1'b0, divisor}) begin
                rem_next = rem_sub[DW-1:0];
                dvd_next = {dvd_reg[NW-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[DW-1:0];
                dvd_next = {dvd_reg[NW-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == SCW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

FILE: tb/clipped_box_mean_filter_core_tb.sv
`timescale 1ns / 1ps

module clipped_box_mean_filter_core_tb;
    import cbmf_pkg::*;

    localparam int STORE_DEPTH =
        (2 * DEF_MAX_RADIUS + 1) * DEF_MAX_WIDTH + 2 * DEF_MAX_RADIUS + 1;
    // worst result: full 31x31 window plus divider, with margin for output stalls
    localparam int SETTLE = 1200;
    localparam longint CYCLE_LIMIT = 5_000_000;
    localparam int RANDOM_ITEMS = 1800;
    localparam int N_DIRECTED = 30;

    logic                        aclk;
    logic                        aresetn;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [PIXEL_BITS-1:0]       s_tdata;   // [7:0] pixel
    logic                        s_tuser;   // [0] mode
    logic                        m_tvalid;
    logic                        m_tready;
    // [15:0] mean_value, [25:16] out_column, [41:26] out_row, [47:42] zero
    logic [M_DATA_BITS-1:0]      m_tdata;
    logic                        m_tlast;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [1:0]                  cfg_index;
    logic [CFG_HEIGHT_BITS-1:0]  cfg_data;

    clipped_box_mean_filter_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    typedef struct packed {
        logic [MEAN_BITS-1:0]    mean;
        logic [OUT_COL_BITS-1:0] col;
        logic [ROW_BITS-1:0]     row;
        logic                    last;
    } mean_result_t;

    typedef struct packed {
        logic        is_cfg;
        cfg_index_t  idx;
        logic [15:0] value;
        logic        mode;
        logic [7:0]  pixel;
        logic        pinned;
        logic [15:0] mean;
    } dir_row_t;

    // filter state mirror
    logic [7:0]      pix_ring [STORE_DEPTH];
    int unsigned     reg_w, reg_h, reg_r;
    int unsigned     act_w, act_h, act_r;
    int unsigned     in_col, in_row;
    longint unsigned out_pos;

    mean_result_t    mean_expq[$];
    int              errors;
    longint          cycles;
    int              burst_left;
    bit              busy;
    int              counted;
    int              rdy_mode;
    int              rdy_cnt;

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    task automatic report(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    function automatic mean_result_t window_mean();
        longint unsigned w, h, r, oy, ox, y0, y1, x0, x1, sum, cnt;
        mean_result_t res;
        w = act_w;
        h = act_h;
        r = act_r;
        oy = out_pos / w;
        ox = out_pos % w;
        y0 = (oy > r) ? oy - r : 0;
        y1 = (oy + r < h - 1) ? oy + r : h - 1;
        x0 = (ox > r) ? ox - r : 0;
        x1 = (ox + r < w - 1) ? ox + r : w - 1;
        sum = 0;
        cnt = 0;
        for (longint unsigned yy = y0; yy <= y1; yy++) begin
            for (longint unsigned xx = x0; xx <= x1; xx++) begin
                sum += pix_ring[(yy * w + xx) % STORE_DEPTH];
                cnt++;
            end
        end
        res.mean = MEAN_BITS'((sum * 256) / cnt);
        res.col = OUT_COL_BITS'(ox);
        res.row = ROW_BITS'(oy);
        out_pos++;
        if (out_pos >= w * h) begin
            res.last = 1'b1;
            in_col = 0;
            in_row = 0;
            out_pos = 0;
        end else begin
            res.last = 1'b0;
        end
        return res;
    endfunction

    function automatic bit filter_step(input bit mode, input logic [7:0] pix,
                                       output mean_result_t res);
        bit all_in;
        longint unsigned received, lag;
        res = '0;
        if (in_col == 0 && in_row == 0 && out_pos == 0) begin
            if (mode) return 0;
            // new image: pick up the registers
            act_w = (reg_w == 0) ? 1 : (reg_w > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : reg_w);
            act_h = (reg_h == 0) ? 1 : reg_h;
            act_r = (reg_r > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : reg_r;
        end
        all_in = (in_row >= act_h);
        if (mode) begin
            if (!all_in) return 0;
            res = window_mean();
            return 1;
        end
        if (all_in) return 0;
        received = longint'(in_row) * act_w + in_col;
        pix_ring[received % STORE_DEPTH] = pix;
        in_col++;
        if (in_col >= act_w) begin
            in_col = 0;
            in_row++;
        end
        received++;
        lag = longint'(act_r) * act_w + act_r;
        if (out_pos + lag < received) begin
            res = window_mean();
            return 1;
        end
        return 0;
    endfunction

    task automatic send_item(input bit mode, input logic [7:0] pix,
                             input bit pinned, input logic [15:0] pinned_mean);
        mean_result_t res;
        bit got;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= mode;
        do @(posedge aclk); while (!s_tready);
        got = filter_step(mode, pix, res);
        if (pinned) begin
            if (!got) report("directed row expects a result the filter cannot give");
            res.mean = pinned_mean;
        end
        if (got) mean_expq.push_back(res);
        busy = 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 9)) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                      : $urandom_range(1, 24);
        end
    endtask

    task automatic park_input();
        if (s_tvalid) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
    endtask

    task automatic wait_drained();
        park_input();
        while (mean_expq.size() != 0) @(posedge aclk);
        if (busy) begin
            repeat (SETTLE) @(posedge aclk);
            busy = 1'b0;
        end
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
        wait_drained();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_IMAGE_WIDTH:   reg_w = val[CFG_WIDTH_BITS-1:0];
            REG_IMAGE_HEIGHT:  reg_h = val;
            REG_WINDOW_RADIUS: reg_r = val[CFG_RADIUS_BITS-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // one image of npix pixels with stray flushes, then flush ticks till it closes
    task automatic run_image(input int npix);
        for (int k = 0; k < npix; k++) begin
            if ($urandom_range(0, 19) == 0) send_item(1'b1, 8'($urandom), 1'b0, '0);
            send_item(1'b0, 8'($urandom), 1'b0, '0);
            counted++;
        end
        while (in_col != 0 || in_row != 0 || out_pos != 0) begin
            if ($urandom_range(0, 9) == 0) begin
                send_item(1'b0, 8'($urandom), 1'b0, '0);
            end else begin
                send_item(1'b1, 8'($urandom), 1'b0, '0);
                counted++;
            end
        end
    endtask

    always @(posedge aclk) begin : result_check
        mean_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (mean_expq.size() == 0) begin
                report($sformatf("result with nothing pending, data %h", m_tdata));
            end else begin
                e = mean_expq.pop_front();
                if (m_tdata[15:0] !== e.mean)
                    report($sformatf("mean_value %h, want %h (row %0d col %0d)",
                                     m_tdata[15:0], e.mean, e.row, e.col));
                if (m_tdata[25:16] !== e.col)
                    report($sformatf("out_column %0d, want %0d", m_tdata[25:16], e.col));
                if (m_tdata[41:26] !== e.row)
                    report($sformatf("out_row %0d, want %0d", m_tdata[41:26], e.row));
                if (m_tlast !== e.last)
                    report($sformatf("frame_last %b, want %b (row %0d col %0d)",
                                     m_tlast, e.last, e.row, e.col));
            end
        end
    end

    // receiver: a new stall pattern is drawn whenever the random run counter expires
    always @(negedge aclk) begin
        if (rdy_cnt == 0) begin
            rdy_mode = $urandom_range(0, 3);
            rdy_cnt = $urandom_range(50, 400);
        end
        rdy_cnt--;
        case (rdy_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ($urandom_range(0, 7) == 0);
            default: m_tready <= ((rdy_cnt % 16) < 10);
        endcase
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("clipped_box_mean_filter_core verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        dir_row_t directed [N_DIRECTED];
        int w, h, r;
        directed = '{
            '{1'b0, REG_UNUSED,        16'h0000, 1'b1, 8'd0,   1'b0, 16'h0000},
            '{1'b1, REG_IMAGE_HEIGHT,  16'hFFFF, 1'b0, 8'd0,   1'b0, 16'h0000},
            '{1'b1, REG_IMAGE_WIDTH,   16'd2,    1'b0, 8'd0,   1'b0, 16'h0000},
            '{1'b1, REG_IMAGE_HEIGHT,  16'd2,    1'b0, 8'd0,   1'b0, 16'h0000},
            '{1'b1, REG_WINDOW_RADIUS, 16'd0,    1'b0, 8'd0,   1'b0, 16'h0000},
            '{1'b0, REG_UNUSED,        16'h0000, 1'b0, 8'd0,   1'b1, 16'h0000},
            '{1'b0, REG_UNUSED,        16'h0000, 1'b1, 8'd99,  1'b0, 16'h0000},
            '{1'b0, REG_UNUSED,        16'h0000, 1'b0, 8'd255, 1'b1, 16'hFF00},
            '{1'b0, REG_UNUSED,        16'h0000, 1'b0, 8'd128, 1'b1, 16'h8000},
            '{1'b0, REG_UNUSED,        16'h0000, 1'b0, 8'd1,   1'b1, 16'h0100},
            // width zero after masking, height zero, radius pinned at max
            '{1'b1, REG_IMAGE_WIDTH,   16'hF800, 1'b0, 8'd0,   1'b0, 16'h0000},
            '{1'b1, REG_IMAGE_HEIGHT,  16'h0000, 1'b0, 8'd0,   1'b0, 16'h0000},
            '{1'b1, REG_WINDOW_RADIUS, 16'hFFFF, 1'b0, 8'd0,   1'b0, 16'h0000},
            '{1'b1, REG_UNUSED,        16'h5A5A, 1'b0, 8'd0,   1'b0, 16'h0000},
            '{1'b0, REG_UNUSED,        16'h0000, 1'b0, 8'd200, 1'b0, 16'h0000},
            '{1'b0, REG_UNUSED,        16'h0000, 1'b0, 8'd7,   1'b0, 16'h0000},
            '{1'b0, REG_UNUSED,        16'h0000, 1'b1, 8'd0,   1'b1, 16'hC800},
            '{1'b1, REG_IMAGE_WIDTH,   16'd3,    1'b0, 8'd0,   1'b0, 16'h0000},
            '{1'b1, REG_IMAGE_HEIGHT,  16'd2,    1'b0, 8'd0,   1'b0, 16'h0000},
            '{1'b1, REG_WINDOW_RADIUS, 16'd1,    1'b0, 8'd0,   1'b0, 16'h0000},
            '{1'b0, REG_UNUSED,        16'h0000, 1'b0, 8'd10,  1'b0, 16'h0000},
            '{1'b0, REG_UNUSED,        16'h0000, 1'b0, 8'd20,  1'b0, 16'h0000},
            '{1'b0, REG_UNUSED,        16'h0000, 1'b0, 8'd30,  1'b0, 16'h0000},
            '{1'b0, REG_UNUSED,        16'h0000, 1'b0, 8'd40,  1'b0, 16'h0000},
            '{1'b0, REG_UNUSED,        16'h0000, 1'b0, 8'd50,  1'b0, 16'h0000},
            '{1'b0, REG_UNUSED,        16'h0000, 1'b0, 8'd60,  1'b0, 16'h0000},
            '{1'b0, REG_UNUSED,        16'h0000, 1'b1, 8'd0,   1'b0, 16'h0000},
            '{1'b0, REG_UNUSED,        16'h0000, 1'b1, 8'd0,   1'b0, 16'h0000},
            '{1'b0, REG_UNUSED,        16'h0000, 1'b1, 8'd0,   1'b0, 16'h0000},
            '{1'b0, REG_UNUSED,        16'h0000, 1'b1, 8'd0,   1'b0, 16'h0000}
        };

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_IMAGE_WIDTH;
        cfg_data  = '0;
        errors    = 0;
        cycles    = 0;
        counted   = 0;
        busy      = 1'b0;
        rdy_cnt   = 0;
        burst_left = $urandom_range(1, 24);
        reg_w = DEF_MAX_WIDTH;
        reg_h = 1024;
        reg_r = 1;
        act_w = reg_w;
        act_h = reg_h;
        act_r = reg_r;
        in_col = 0;
        in_row = 0;
        out_pos = 0;
        for (int i = 0; i < STORE_DEPTH; i++) pix_ring[i] = '0;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) begin
            if (directed[i].is_cfg)
                write_reg(directed[i].idx, directed[i].value);
            else
                send_item(directed[i].mode, directed[i].pixel,
                          directed[i].pinned, directed[i].mean);
        end

        // widest image: width value clamps to the built maximum
        write_reg(REG_IMAGE_WIDTH, 16'h07FF);
        write_reg(REG_IMAGE_HEIGHT, 16'd1);
        write_reg(REG_WINDOW_RADIUS, 16'd1);
        run_image(DEF_MAX_WIDTH);

        while (counted < RANDOM_ITEMS) begin
            if ($urandom_range(0, 15) == 0) begin
                r = DEF_MAX_RADIUS;
                w = $urandom_range(1, 8);
                h = $urandom_range(1, 4);
            end else begin
                r = $urandom_range(0, 3);
                w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64)
                                                : $urandom_range(1, 16);
                h = $urandom_range(1, 8);
            end
            if (reg_w != w || $urandom_range(0, 3) != 0)
                write_reg(REG_IMAGE_WIDTH, {5'($urandom), 11'(w)});
            if (reg_h != h || $urandom_range(0, 3) != 0)
                write_reg(REG_IMAGE_HEIGHT, 16'(h));
            if (reg_r != r || $urandom_range(0, 3) != 0)
                write_reg(REG_WINDOW_RADIUS, {12'($urandom), 4'(r)});
            if ($urandom_range(0, 15) == 0)
                write_reg(REG_UNUSED, 16'($urandom));
            run_image(w * h);
        end

        wait_drained();
        if (errors == 0) begin
            $display("clipped_box_mean_filter_core verification clean");
        end else begin
            $display("clipped_box_mean_filter_core verification failed");
        end
        $finish;
    end

endmodule

FILE: clipped_box_mean_filter_core.f
hdl/cbmf_pkg.sv
hdl/cbmf_store.sv
hdl/cbmf_div.sv
hdl/clipped_box_mean_filter_core.sv
tb/clipped_box_mean_filter_core_tb.sv
